// ===== hw/rtl/pcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrc_pkg: shared types and constants for the packet serial CRC link engine
// Item layouts, function and result codes, register indexes, CRC-16 helper.
// ----------------------------------------------------------------------------
package pcrc_pkg;

  localparam int PayloadDepthDef = 48;

  // input function codes
  localparam logic [1:0] FUNC_WR   = 2'd0;
  localparam logic [1:0] FUNC_RD   = 2'd1;
  localparam logic [1:0] FUNC_RX   = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_WR_DONE = 2'd1;
  localparam logic [1:0] KIND_RD_DONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_RETRY    = 2'd2;

  localparam logic [7:0]  DevAddrRst  = 8'd128;
  localparam logic [15:0] TimeoutRst  = 16'd5;
  localparam logic [2:0]  RetryRst    = 3'd2;
  localparam logic [15:0] TimeoutDflt = 16'd5;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcTopBit = 16'h8000;
  localparam logic [7:0]  AckByte   = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        ok;
    logic [31:0] value;
    logic [7:0]  status_byte;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] timeout;
    logic [2:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  // CRC-16 (poly 0x1021, MSB first), one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTopBit) != 16'h0) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pcrc_chan_if.sv =====
// ----------------------------------------------------------------------------
// pcrc_chan_if: valid/ready channel
// Carries one item per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface pcrc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pcrc_ram.sv =====
// ----------------------------------------------------------------------------
// pcrc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pcrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pcrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcrc_ctrl: link sequencer
// Collects frames into the frame store, walks it to send, checks replies.
// ----------------------------------------------------------------------------
module pcrc_ctrl #(
  parameter int PAYLOAD_DEPTH = pcrc_pkg::PayloadDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcrc_pkg::cfg_t cfg_i,
  pcrc_chan_if.sink      in_i,
  input  logic           emit_ready_i,
  output pcrc_pkg::emit_t emit_o
);
  import pcrc_pkg::*;

  localparam int IdxW = $clog2(PAYLOAD_DEPTH);
  localparam int LenW = $clog2(PAYLOAD_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SEND_ADDR = 8'b0000_0010,
    S_SEND_RD   = 8'b0000_0100,
    S_SEND_BYTE = 8'b0000_1000,
    S_CRC_HI    = 8'b0001_0000,
    S_CRC_LO    = 8'b0010_0000,
    S_WAIT      = 8'b0100_0000,
    S_RESULT    = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            collect_q, collect_d;
  logic            is_read_q, is_read_d;
  logic [2:0]      retries_q, retries_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      rcrc_hi_q, rcrc_hi_d;
  logic [2:0]      ridx_q, ridx_d;
  logic [31:0]     rval_q, rval_d;
  logic [7:0]      rstat_q, rstat_d;
  logic [15:0]     wt_q, wt_d;
  logic            res_ok_q, res_ok_d;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_rdata;

  in_item_t        item;
  logic            in_ready, in_fire, last_byte, fail;
  logic [LenW-1:0] eff_len;
  logic [15:0]     limit, wt_inc;

  pcrc_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign item      = in_i.payload;
  assign in_ready  = (state_q == S_IDLE) || (state_q == S_WAIT);
  assign in_i.ready = in_ready;
  assign in_fire   = in_i.valid && in_ready;
  assign last_byte = (LenW'(idx_q) + LenW'(1)) == len_q;
  assign eff_len   = collect_q ? len_q : '0;
  assign limit     = (cfg_i.timeout == 16'h0) ? TimeoutDflt : cfg_i.timeout;
  assign wt_inc    = (wt_q == 16'hFFFF) ? wt_q : wt_q + 16'd1;

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    collect_d = collect_q;
    is_read_d = is_read_q;
    retries_d = retries_q;
    crc_d     = crc_q;
    rcrc_hi_d = rcrc_hi_q;
    ridx_d    = ridx_q;
    rval_d    = rval_q;
    rstat_d   = rstat_q;
    wt_d      = wt_q;
    res_ok_d  = res_ok_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    fail      = 1'b0;
    emit_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (item.func)
            FUNC_WR: begin
              collect_d = 1'b1;
              if (eff_len < LenW'(PAYLOAD_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = eff_len[IdxW-1:0];
                len_d     = eff_len + LenW'(1);
              end else begin
                len_d = eff_len;
              end
              if (item.last) begin
                collect_d = 1'b0;
                is_read_d = 1'b0;
                retries_d = cfg_i.retry_limit;
                state_d   = S_SEND_ADDR;
              end
            end
            FUNC_RD: begin
              if (!collect_q) begin
                ram_we    = 1'b1;
                len_d     = LenW'(1);
                is_read_d = 1'b1;
                retries_d = cfg_i.retry_limit;
                state_d   = S_SEND_ADDR;
              end
            end
            default: ;  // stray rx bytes and idle ticks dropped
          endcase
        end
      end

      S_SEND_ADDR: begin
        if (emit_ready_i) begin
          emit_o.valid        = 1'b1;
          emit_o.item.kind    = KIND_TX;
          emit_o.item.tx_byte = cfg_i.dev_addr;
          crc_d   = crc16_byte(16'h0, cfg_i.dev_addr);
          idx_d   = '0;
          wt_d    = '0;
          ridx_d  = '0;
          rval_d  = '0;
          rstat_d = '0;
          rcrc_hi_d = '0;
          state_d = S_SEND_RD;
        end
      end

      S_SEND_RD: begin
        ram_re  = 1'b1;
        state_d = S_SEND_BYTE;
      end

      S_SEND_BYTE: begin
        if (emit_ready_i) begin
          emit_o.valid        = 1'b1;
          emit_o.item.kind    = KIND_TX;
          emit_o.item.tx_byte = ram_rdata;
          emit_o.item.run_end = last_byte && is_read_q;
          crc_d = crc16_byte(crc_q, ram_rdata);
          if (last_byte) begin
            state_d = is_read_q ? S_WAIT : S_CRC_HI;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_SEND_RD;
          end
        end
      end

      S_CRC_HI: begin
        if (emit_ready_i) begin
          emit_o.valid        = 1'b1;
          emit_o.item.kind    = KIND_TX;
          emit_o.item.tx_byte = crc_q[15:8];
          state_d = S_CRC_LO;
        end
      end

      S_CRC_LO: begin
        if (emit_ready_i) begin
          emit_o.valid        = 1'b1;
          emit_o.item.kind    = KIND_TX;
          emit_o.item.tx_byte = crc_q[7:0];
          emit_o.item.run_end = 1'b1;
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        if (in_fire) begin
          case (item.func)
            FUNC_RX: begin
              if (!is_read_q) begin
                if (item.data == AckByte) begin
                  res_ok_d = 1'b1;
                  state_d  = S_RESULT;
                end else begin
                  fail = 1'b1;
                end
              end else begin
                wt_d = '0;
                if (ridx_q < 3'd4) begin
                  rval_d = {rval_q[23:0], item.data};
                  crc_d  = crc16_byte(crc_q, item.data);
                  ridx_d = ridx_q + 3'd1;
                end else if (ridx_q == 3'd4) begin
                  rstat_d = item.data;
                  crc_d   = crc16_byte(crc_q, item.data);
                  ridx_d  = ridx_q + 3'd1;
                end else if (ridx_q == 3'd5) begin
                  rcrc_hi_d = item.data;
                  ridx_d    = ridx_q + 3'd1;
                end else if ({rcrc_hi_q, item.data} == crc_q) begin
                  res_ok_d = 1'b1;
                  state_d  = S_RESULT;
                end else begin
                  fail = 1'b1;
                end
              end
            end
            FUNC_TICK: begin
              wt_d = wt_inc;
              if (wt_inc >= limit) begin
                fail = 1'b1;
              end
            end
            default: ;  // busy: new requests ignored
          endcase
        end
        if (fail) begin
          if (retries_q != 3'd0) begin
            retries_d = retries_q - 3'd1;
            state_d   = S_SEND_ADDR;
          end else begin
            res_ok_d = 1'b0;
            state_d  = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (emit_ready_i) begin
          emit_o.valid            = 1'b1;
          emit_o.item.kind        = is_read_q ? KIND_RD_DONE : KIND_WR_DONE;
          emit_o.item.ok          = res_ok_q;
          emit_o.item.value       = res_ok_q ? rval_q : 32'h0;
          emit_o.item.status_byte = res_ok_q ? rstat_q : 8'h0;
          emit_o.item.run_end     = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      idx_q     <= '0;
      collect_q <= 1'b0;
      is_read_q <= 1'b0;
      retries_q <= '0;
      crc_q     <= '0;
      rcrc_hi_q <= '0;
      ridx_q    <= '0;
      rval_q    <= '0;
      rstat_q   <= '0;
      wt_q      <= '0;
      res_ok_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      collect_q <= collect_d;
      is_read_q <= is_read_d;
      retries_q <= retries_d;
      crc_q     <= crc_d;
      rcrc_hi_q <= rcrc_hi_d;
      ridx_q    <= ridx_d;
      rval_q    <= rval_d;
      rstat_q   <= rstat_d;
      wt_q      <= wt_d;
      res_ok_q  <= res_ok_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> emit_ready_i)
    else $error("item emitted into a full output stage");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(PAYLOAD_DEPTH))
    else $error("frame length beyond frame store");

  a_reply_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ridx_q <= 3'd6)
    else $error("reply index out of range");

  a_read_then_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND_RD) |=> (state_q == S_SEND_BYTE))
    else $error("store read not followed by byte send");

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND_BYTE) |-> (LenW'(idx_q) < len_q))
    else $error("send index past frame length");
`endif

endmodule

// ===== hw/rtl/packet_serial_crc_link_engine_unit.sv =====
// ----------------------------------------------------------------------------
// packet_serial_crc_link_engine_unit: host side of an addressed serial link
// Frames write commands with CRC-16, waits for ack or CRC-checked reply, retries on failure.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     func, data, last
//  out_o     out  valid/ready     kind, tx_byte, ok, value, status_byte, run_end
//  cfg       in   cfg_we_i only   cfg_idx_i, cfg_wdata_i
//
//  A frame send emits the address, then each stored byte as a frame store
//  read followed by the send, then the CRC of a write frame; the failed/done
//  result follows as a separate item. Reset (rst_ni, async low) returns to
//  idle with default registers; the frame store holds no reset state. A
//  stalled out_o holds the sequencer in place; in_i is taken only while idle
//  or waiting for a reply.
// ----------------------------------------------------------------------------
module packet_serial_crc_link_engine_unit #(
  parameter int PAYLOAD_DEPTH = pcrc_pkg::PayloadDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcrc_chan_if.sink   in_i,
  pcrc_chan_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import pcrc_pkg::*;

  cfg_t      cfg_q;
  emit_t     emit;
  logic      emit_ready;
  logic      out_valid_q;
  out_item_t out_item_q;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= DevAddrRst;
      cfg_q.timeout     <= TimeoutRst;
      cfg_q.retry_limit <= RetryRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEV_ADDR: cfg_q.dev_addr    <= cfg_wdata_i[7:0];
        CFG_TIMEOUT:  cfg_q.timeout     <= cfg_wdata_i;
        CFG_RETRY:    cfg_q.retry_limit <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  pcrc_ctrl #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .emit_ready_i (emit_ready),
    .emit_o       (emit)
  );

  // output register: sequencer may load a new item as the old one leaves
  assign emit_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_item_q <= emit.item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule
